// ----- rtl/quadratic_probe_hash_insert_macros.svh -----
// Assertion macros for the quadratic probing hash insert block.
`ifndef QUADRATIC_PROBE_HASH_INSERT_MACROS_SVH
`define QUADRATIC_PROBE_HASH_INSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define QPHI_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define QPHI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define QPHI_ASSERT_IMPLIES(label, ante, cons, msg)
`define QPHI_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ----- rtl/qphi_pkg.sv -----
// Shared constants and command and status types of the quadratic probing hash insert block.
`default_nettype none
package qphi_pkg;

  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int DEF_MAX_PROBES  = 64;

  localparam int KEY_W       = 64;
  localparam int VALUE_W     = 64;
  localparam int SLOT_OUT_W  = 10;
  localparam int COUNT_OUT_W = 7;
  localparam int TS_W        = 11;
  localparam int EB_W        = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 11;
  localparam int DIV_CNT_W   = $clog2(KEY_W);
  localparam int ENTRY_MAX_BYTES = VALUE_W / 8;

  localparam logic [TS_W-1:0] RESET_TABLE_SIZE  = 11'd1021;
  localparam logic [EB_W-1:0] RESET_ENTRY_BYTES = 4'd8;
  localparam logic [7:0]      BLANK_BYTE        = 8'hFF;

  localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_BYTES = 2'd1;

  typedef struct packed {
    logic clear_step;
    logic load;
    logic div_load;
    logic div_step;
    logic read;
    logic advance;
    logic write;
    logic out_ok;
    logic out_fail;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic div_last;
    logic blank;
    logic last_probe;
    logic wrap;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- rtl/qphi_datapath.sv -----
// Datapath: configuration registers, slot memory, bit-serial remainder unit and probe arithmetic.
`default_nettype none
module qphi_datapath #(
  parameter int TABLE_DEPTH = qphi_pkg::DEF_TABLE_DEPTH,
  parameter int MAX_PROBES  = qphi_pkg::DEF_MAX_PROBES
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_valid,
  input  wire logic [qphi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [qphi_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic [qphi_pkg::KEY_W-1:0]         key_hash,
  input  wire logic [qphi_pkg::VALUE_W-1:0]       store_value,
  input  wire qphi_pkg::ctrl_cmd_t                cmd,
  output qphi_pkg::dp_stat_t                      stat,
  input  wire logic                               out_stall,
  output logic                                    out_valid,
  output logic [qphi_pkg::SLOT_OUT_W-1:0]         slot_written,
  output logic [qphi_pkg::COUNT_OUT_W-1:0]        probe_count,
  output logic                                    no_space
);
  import qphi_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int SW = $clog2(TABLE_DEPTH + 1);
  localparam int CW = (SW > TS_W) ? SW : TS_W;
  localparam int PW = $clog2(MAX_PROBES + 1);
  localparam int FAIL_COUNT = (MAX_PROBES > 127) ? 127 : MAX_PROBES;

  logic [TS_W-1:0]    table_size;
  logic [EB_W-1:0]    entry_bytes;
  logic [CW-1:0]      size_c;
  logic [SW-1:0]      size_eff;
  logic [2:0]         top_eff;
  logic [SW-1:0]      size_reg;
  logic [2:0]         top_reg;
  logic [VALUE_W-1:0] value_reg;
  logic [KEY_W-1:0]   sum;
  logic [KEY_W:0]     sum_adv;
  logic [KEY_W-1:0]   dividend;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [SW-1:0]      res;
  logic [SW-1:0]      res_next;
  logic [SW-1:0]      step;
  logic [SW-1:0]      step_next;
  logic [SW:0]        rem_try;
  logic [SW:0]        res_add;
  logic [SW:0]        step_add;
  logic [PW-1:0]      probe;
  logic [AW-1:0]      clear_addr;
  logic [VALUE_W-1:0] rd_data;
  logic [VALUE_W-1:0] merged;
  logic [VALUE_W-1:0] slot_mem [TABLE_DEPTH];
  logic [SW+SLOT_OUT_W-1:0]  slot_wide;
  logic [PW+COUNT_OUT_W-1:0] count_wide;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size  <= RESET_TABLE_SIZE;
      entry_bytes <= RESET_ENTRY_BYTES;
    end else if (cfg_valid) begin
      if (cfg_index == REG_TABLE_SIZE) begin
        table_size <= cfg_data;
      end else if (cfg_index == REG_ENTRY_BYTES) begin
        entry_bytes <= cfg_data[EB_W-1:0];
      end
    end
  end

  always_comb begin
    priority if (table_size == '0) begin
      size_c = CW'(1);
    end else if (CW'(table_size) > CW'(TABLE_DEPTH)) begin
      size_c = CW'(TABLE_DEPTH);
    end else begin
      size_c = CW'(table_size);
    end
    size_eff = size_c[SW-1:0];
    priority if (entry_bytes == '0) begin
      top_eff = 3'd0;
    end else if (entry_bytes > EB_W'(ENTRY_MAX_BYTES)) begin
      top_eff = 3'd7;
    end else begin
      top_eff = 3'(entry_bytes - EB_W'(1));
    end
  end

  always_comb begin
    sum_adv  = {1'b0, sum} + (KEY_W + 1)'({probe, 1'b1});
    rem_try  = {res, dividend[KEY_W-1]};
    res_add  = {1'b0, res} + {1'b0, step};
    step_add = {1'b0, step} + (SW + 1)'(2);
    res_next = res;
    if (cmd.div_step) begin
      if (rem_try >= {1'b0, size_reg}) begin
        res_next = SW'(rem_try - {1'b0, size_reg});
      end else begin
        res_next = rem_try[SW-1:0];
      end
    end else if (cmd.advance) begin
      if (res_add >= {1'b0, size_reg}) begin
        res_next = SW'(res_add - {1'b0, size_reg});
      end else begin
        res_next = res_add[SW-1:0];
      end
    end else if (cmd.div_load) begin
      res_next = '0;
    end
    priority if (step_add >= {size_reg, 1'b0}) begin
      step_next = SW'(step_add - {size_reg, 1'b0});
    end else if (step_add >= {1'b0, size_reg}) begin
      step_next = SW'(step_add - {1'b0, size_reg});
    end else begin
      step_next = step_add[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
    if (cmd.load) begin
      size_reg  <= size_eff;
      top_reg   <= top_eff;
      value_reg <= store_value;
      sum       <= key_hash;
      probe     <= '0;
      step      <= (size_eff == SW'(1)) ? '0 : SW'(1);
    end else if (cmd.advance) begin
      sum   <= sum_adv[KEY_W-1:0];
      probe <= probe + PW'(1);
      step  <= step_next;
    end
    if (cmd.div_load) begin
      dividend <= sum;
    end else if (cmd.div_step) begin
      dividend <= {dividend[KEY_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt    <= '0;
      clear_addr <= '0;
    end else begin
      if (cmd.div_load) begin
        div_cnt <= '0;
      end else if (cmd.div_step) begin
        div_cnt <= div_cnt + DIV_CNT_W'(1);
      end
      if (cmd.clear_step) begin
        clear_addr <= clear_addr + AW'(1);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < ENTRY_MAX_BYTES; k++) begin
      if (3'(k) <= top_reg) begin
        merged[k*8 +: 8] = value_reg[k*8 +: 8];
      end else begin
        merged[k*8 +: 8] = rd_data[k*8 +: 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      slot_mem[clear_addr] <= '1;
    end else if (cmd.write) begin
      slot_mem[res[AW-1:0]] <= merged;
    end
    if (cmd.read) begin
      rd_data <= slot_mem[res[AW-1:0]];
    end
  end

  assign slot_wide  = {{SLOT_OUT_W{1'b0}}, res};
  assign count_wide = {{COUNT_OUT_W{1'b0}}, probe};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_ok || cmd.out_fail) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ok) begin
      slot_written <= slot_wide[SLOT_OUT_W-1:0];
      probe_count  <= count_wide[COUNT_OUT_W-1:0];
      no_space     <= 1'b0;
    end else if (cmd.out_fail) begin
      slot_written <= '0;
      probe_count  <= COUNT_OUT_W'(FAIL_COUNT);
      no_space     <= 1'b1;
    end
  end

  always_comb begin
    stat.clear_last = (clear_addr == AW'(TABLE_DEPTH - 1));
    stat.div_last   = (div_cnt == DIV_CNT_W'(KEY_W - 1));
    stat.blank      = (rd_data[top_reg*8 +: 8] == BLANK_BYTE);
    stat.last_probe = (probe == PW'(MAX_PROBES - 1));
    stat.wrap       = sum_adv[KEY_W];
    stat.out_free   = !out_valid || !out_stall;
  end

endmodule
`default_nettype wire

// ----- rtl/qphi_ctrl.sv -----
// Controller state machine sequencing the clearing sweep, remainder steps and slot probes.
`default_nettype none
module qphi_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire qphi_pkg::dp_stat_t  stat,
  output qphi_pkg::ctrl_cmd_t      cmd
);
  import qphi_pkg::*;

  typedef enum logic [7:0] {
    S_CLEAR     = 8'b0000_0001,
    S_IDLE      = 8'b0000_0010,
    S_DIV_LOAD  = 8'b0000_0100,
    S_DIV       = 8'b0000_1000,
    S_READ      = 8'b0001_0000,
    S_CHECK     = 8'b0010_0000,
    S_DONE_OK   = 8'b0100_0000,
    S_DONE_FAIL = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DIV_LOAD;
        end
      end
      S_DIV_LOAD: begin
        cmd.div_load = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        priority if (stat.blank) begin
          cmd.write  = 1'b1;
          state_next = S_DONE_OK;
        end else if (stat.last_probe) begin
          state_next = S_DONE_FAIL;
        end else begin
          cmd.advance = 1'b1;
          state_next  = stat.wrap ? S_DIV_LOAD : S_READ;
        end
      end
      S_DONE_OK: begin
        if (stat.out_free) begin
          cmd.out_ok = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DONE_FAIL: begin
        if (stat.out_free) begin
          cmd.out_fail = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  assign in_stall = (state != S_IDLE);

endmodule
`default_nettype wire

// ----- rtl/quadratic_probe_hash_insert.sv -----
// Top level of the quadratic probing hash insert block: controller, datapath and checks.
// An insert runs from the accepted beat through a remainder pass, then a read and a check
// of each probed slot, and then waits until the output is free to give its result beat;
// the input stays stalled until that result beat is shown. The remainder unit has 64 steps,
// and a 64-bit wrap of hash plus probe offset adds another remainder pass before the read.
// After reset the slot memory is swept to all ones, input stalled.
`default_nettype none
`include "quadratic_probe_hash_insert_macros.svh"
module quadratic_probe_hash_insert #(
  parameter int TABLE_DEPTH = qphi_pkg::DEF_TABLE_DEPTH,
  parameter int MAX_PROBES  = qphi_pkg::DEF_MAX_PROBES
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [qphi_pkg::KEY_W-1:0]       key_hash,
  input  wire logic [qphi_pkg::VALUE_W-1:0]     store_value,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [qphi_pkg::SLOT_OUT_W-1:0]       slot_written,
  output logic [qphi_pkg::COUNT_OUT_W-1:0]      probe_count,
  output logic                                  no_space,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [qphi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [qphi_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import qphi_pkg::*;

  localparam int FAIL_COUNT = (MAX_PROBES > 127) ? 127 : MAX_PROBES;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  qphi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  qphi_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .MAX_PROBES  (MAX_PROBES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .key_hash     (key_hash),
    .store_value  (store_value),
    .cmd          (cmd),
    .stat         (stat),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .slot_written (slot_written),
    .probe_count  (probe_count),
    .no_space     (no_space)
  );

  `QPHI_ASSERT_NEXT(a_accept_then_busy, in_valid && !in_stall, in_stall, "Second beat taken while an insert is in progress.")
  `QPHI_ASSERT_IMPLIES(a_clear_stalls, cmd.clear_step, in_stall, "Input not stalled during the clearing sweep.")
  `QPHI_ASSERT_IMPLIES(a_fail_fields, out_valid && no_space, (probe_count == COUNT_OUT_W'(FAIL_COUNT)) && (slot_written == '0), "Failed insert carries wrong result fields.")

endmodule
`default_nettype wire
